@@ sv/fpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// shared widths and codes for the linked free-list page allocator
// ----------------------------------------------------------------------------
package fpa_pkg;

    // fixed field widths
    localparam int ADDR_W   = 39;
    localparam int SIZE_W   = 23;
    localparam int FREE_W   = 11;
    localparam int STATUS_W = 3;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W = 1;

    // shared adder width: one guard bit above the address
    localparam int SUM_W = ADDR_W + 1;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_GET  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUT        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'd1;

endpackage

@@ sv/fifo_free_page_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_free_page_allocator_top
// first-in first-out free page list over a next-pointer memory
// ----------------------------------------------------------------------------
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  in       | i_in_valid  / o_in_ready     | i_func, i_page_address, i_init_bytes
//  out      | o_out_valid / i_out_ready    | o_result_address, o_free_count,
//           |                              | o_status
//  cfg      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  states from input transfer to the result: get S_GET, S_GET_WB, S_RESP (empty
//  get S_RESP only), put S_OFF, S_CMP, S_LINK, S_TERM, S_RESP (rejected put S_OFF,
//  S_CMP, S_RESP), init S_OFF to S_TERM per page, then S_RESP; a page that fails
//  ends the sweep after S_CMP; one shared 40-bit add/subtract unit sets this order
//  one item at a time: o_in_ready is high only while the sequencer is idle
//  the result sits in an output register; a stalled result holds the
//  sequencer in its response state until the output register frees up
//  synchronous active-low reset clears head, tail, count and both config
//  registers; the pointer memory is not cleared
//  config writes are taken in every cycle and belong to idle periods only
// ----------------------------------------------------------------------------
module fifo_free_page_allocator_top
    import fpa_pkg::*;
#(
    parameter int MAX_PAGES = 1024,
    parameter int PAGE_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,

    // operation channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [ADDR_W-1:0]    i_page_address,
    input  logic [SIZE_W-1:0]    i_init_bytes,

    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ADDR_W-1:0]    o_result_address,
    output logic [FREE_W-1:0]    o_free_count,
    output logic [STATUS_W-1:0]  o_status
);

    // page index, free count and init page counter widths
    localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int LEFT_W = SIZE_W - PAGE_BITS;
    localparam int PAD_W  = SUM_W - IDX_W - PAGE_BITS;

    localparam logic [SUM_W-1:0] PAGE_STEP = SUM_W'(1) << PAGE_BITS;
    localparam logic [SUM_W-1:0] MAX_IDX   = SUM_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_PAGES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_GET_WB,
        S_OFF,
        S_CMP,
        S_LINK,
        S_TERM,
        S_RESP
    } t_state;

    t_state r_state;

    // configuration
    logic [ADDR_W-1:0] r_region_base;
    logic [SIZE_W-1:0] r_region_size;

    // list state
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    // working registers of the current operation
    logic [SUM_W-1:0]    r_addr;      // page address, guard bit marks overflow
    logic [SUM_W-1:0]    r_off;       // address minus region base
    logic                r_ge_base;   // address at or above region base
    logic [IDX_W-1:0]    r_idx;       // page index being appended
    logic [LEFT_W-1:0]   r_left;      // pages still to load on init
    logic                r_init;
    logic [ADDR_W-1:0]   r_res_addr;
    logic [STATUS_W-1:0] r_res_status;

    // next-pointer memory, read data registered
    logic [IDX_W-1:0] mem_next [MAX_PAGES];
    logic [IDX_W-1:0] r_rdata;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_waddr;
    logic [IDX_W-1:0] w_mem_wdata;
    logic             w_mem_re;

    // shared add/subtract unit
    logic [SUM_W-1:0] w_opa;
    logic [SUM_W-1:0] w_opb;
    logic             w_sub;
    logic [SUM_W:0]   w_sum;

    logic             w_in_xfer;
    logic             w_out_free;
    logic             w_put_misaligned;
    logic             w_put_out;
    logic             w_init_misaligned;
    logic [CNT_W+FREE_W-1:0] w_count_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !o_out_valid || i_out_ready;
    assign w_count_ext = {{FREE_W{1'b0}}, r_count};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
            r_region_size <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REGION_BASE: r_region_base <= i_cfg_data;
                CFG_REGION_SIZE: r_region_size <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared adder
    always_comb begin
        w_opa = r_addr;
        w_opb = '0;
        w_sub = 1'b0;
        case (r_state)
            S_GET: begin
                // region base plus head page offset
                w_opa = {1'b0, r_region_base};
                w_opb = {{PAD_W{1'b0}}, r_head, {PAGE_BITS{1'b0}}};
            end
            S_OFF: begin
                // offset into the region, carry says address >= base
                w_opa = r_addr;
                w_opb = {1'b0, r_region_base};
                w_sub = 1'b1;
            end
            S_CMP: begin
                // carry says offset >= region size
                w_opa = r_off;
                w_opb = {{(SUM_W-SIZE_W){1'b0}}, r_region_size};
                w_sub = 1'b1;
            end
            S_LINK: begin
                // step to the next page of an init span
                w_opa = r_addr;
                w_opb = PAGE_STEP;
            end
            default: ;
        endcase
    end

    assign w_sum = {1'b0, w_opa} + {1'b0, (w_sub ? ~w_opb : w_opb)} + (SUM_W+1)'(w_sub);

    // put checks, in priority order misaligned, out of region, full
    assign w_put_misaligned = |r_addr[PAGE_BITS-1:0];
    assign w_put_out = r_addr[SUM_W-1] || !r_ge_base || w_sum[SUM_W]
                       || ((r_off >> PAGE_BITS) >= MAX_IDX);
    assign w_init_misaligned = (|i_page_address[PAGE_BITS-1:0])
                               || (|i_init_bytes[PAGE_BITS-1:0]);

    // memory port control: link write from the old tail, then clear new tail
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_idx;
        w_mem_wdata = '0;
        w_mem_re    = (r_state == S_GET);
        case (r_state)
            S_LINK: begin
                w_mem_we    = (r_count != '0);
                w_mem_waddr = r_tail;
                w_mem_wdata = r_idx;
            end
            S_TERM: begin
                w_mem_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_next[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= mem_next[r_head];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // the response state reloads the output register itself
            if (o_out_valid && i_out_ready && (r_state != S_RESP)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_addr       <= {1'b0, i_page_address};
                        r_res_addr   <= '0;
                        r_init       <= 1'b0;
                        r_left       <= i_init_bytes[SIZE_W-1:PAGE_BITS];
                        case (i_func)
                            FUNC_GET: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_GET;
                                end
                            end
                            FUNC_PUT: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_OFF;
                            end
                            FUNC_INIT: begin
                                // list always cleared first
                                r_head  <= '0;
                                r_tail  <= '0;
                                r_count <= '0;
                                r_init  <= 1'b1;
                                if (w_init_misaligned) begin
                                    r_res_status <= ST_MISALIGNED;
                                    r_state      <= S_RESP;
                                end else if (i_init_bytes[SIZE_W-1:PAGE_BITS] == '0) begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_OFF;
                                end
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_GET: begin
                    r_res_addr <= w_sum[ADDR_W-1:0];
                    r_state    <= S_GET_WB;
                end
                S_GET_WB: begin
                    r_head  <= r_rdata;
                    r_count <= r_count - CNT_W'(1);
                    r_state <= S_RESP;
                end
                S_OFF: begin
                    r_off     <= w_sum[SUM_W-1:0];
                    r_ge_base <= w_sum[SUM_W];
                    r_state   <= S_CMP;
                end
                S_CMP: begin
                    r_idx <= r_off[PAGE_BITS +: IDX_W];
                    if (w_put_misaligned) begin
                        r_res_status <= ST_MISALIGNED;
                        r_state      <= S_RESP;
                    end else if (w_put_out) begin
                        r_res_status <= ST_OUT;
                        r_state      <= S_RESP;
                    end else if (r_count >= CNT_FULL) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_RESP;
                    end else begin
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    if (r_count == '0) begin
                        r_head <= r_idx;
                    end
                    r_addr  <= w_sum[SUM_W-1:0];
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_tail  <= r_idx;
                    r_count <= r_count + CNT_W'(1);
                    r_left  <= r_left - LEFT_W'(1);
                    if (r_init && (r_left != LEFT_W'(1))) begin
                        r_state <= S_OFF;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        o_out_valid      <= 1'b1;
                        o_result_address <= r_res_addr;
                        o_free_count     <= w_count_ext[FREE_W-1:0];
                        o_status         <= r_res_status;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/fpa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_checker
// port-level checks on the free page allocator
// ----------------------------------------------------------------------------
module fpa_checker
    import fpa_pkg::*;
#(
    parameter int MAX_PAGES = 1024
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [ADDR_W-1:0]    o_result_address,
    input logic [FREE_W-1:0]    o_free_count,
    input logic [STATUS_W-1:0]  o_status
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_result_address) && $stable(o_free_count) && $stable(o_status))
        else $error("result payload changed while stalled");

    // one operation at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an operation is in flight");

    // only a successful get hands out an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_result_address == '0))
        else $error("address returned with a failing status");

    // free count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_free_count) <= MAX_PAGES))
        else $error("free count above capacity");

endmodule

bind fifo_free_page_allocator_top fpa_checker #(
    .MAX_PAGES(MAX_PAGES)
) u_fpa_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// linked free-list page allocator: get, put and init over changing regions
//
// Operations are planned ahead in an initial block and handed to a clocked
// driver via a queue. A second copy of the free-list state (the planning view)
// steers the random mix: recycled pages, and no get that would walk into a
// never-written next pointer. The checking view is advanced on each accepted
// operation, and a clocked monitor compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
    import fpa_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_TICKS = 11;
    localparam int CYCLE_LIMIT = 4000000;

    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_SLOTS = 1024;
    localparam int IDX_W      = 10;
    localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam int MAX_SPAN   = 4194304;

    localparam bit [63:0] ADDR_MASK64 = (64'd1 << ADDR_W) - 64'd1;
    localparam bit [63:0] SIZE_MASK64 = (64'd1 << SIZE_W) - 64'd1;
    localparam bit [63:0] PAGE_MASK64 = (64'd1 << PAGE_SHIFT) - 64'd1;

    // function code 3 has no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // two copies of the free-list state: one checks results, one plans stimulus
    localparam int VIEW_CHECK = 0;
    localparam int VIEW_PLAN  = 1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] bytes;
    } t_alloc_op;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [FREE_W-1:0]   free;
        logic [STATUS_W-1:0] status;
    } t_alloc_result;

    // clock, reset and all block inputs start at known values
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_REGION_BASE;
    logic [ADDR_W-1:0]    i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic [FUNC_W-1:0]    i_func         = FUNC_GET;
    logic [ADDR_W-1:0]    i_page_address = '0;
    logic [SIZE_W-1:0]    i_init_bytes   = '0;
    logic                 i_out_ready    = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [ADDR_W-1:0]    o_result_address;
    logic [FREE_W-1:0]    o_free_count;
    logic [STATUS_W-1:0]  o_status;

    fifo_free_page_allocator_top #(
        .MAX_PAGES (PAGE_SLOTS),
        .PAGE_BITS (PAGE_SHIFT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_page_address   (i_page_address),
        .i_init_bytes     (i_init_bytes),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_address (o_result_address),
        .o_free_count     (o_free_count),
        .o_status         (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // free-list state, one set per view
    // ------------------------------------------------------------------------
    bit [IDX_W-1:0]  link_tab  [2][PAGE_SLOTS];
    bit              link_set  [2][PAGE_SLOTS];   // entry written at least once
    bit [IDX_W-1:0]  head_q    [2];
    bit [IDX_W-1:0]  tail_q    [2];
    bit [FREE_W-1:0] count_q   [2];
    bit [63:0]       base_q    [2];
    bit [63:0]       size_q    [2];

    t_alloc_op       alloc_requests [$];   // planned, not yet driven
    t_alloc_result   due_results    [$];   // accepted, result not yet seen
    bit [63:0]       recycled_pages [$];   // pages handed out by planned gets

    int err_count;
    int results_seen;
    int settings_done;
    int status_hits [8];
    int cycle_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // append one page at the tail; the order of the checks matters
    function automatic logic [STATUS_W-1:0] link_page(input int v, input bit [63:0] addr);
        bit [63:0] idx;
        if ((addr & PAGE_MASK64) != 0)
            return ST_MISALIGNED;
        if (addr > ADDR_MASK64 || addr < base_q[v] || addr >= base_q[v] + size_q[v])
            return ST_OUT;
        idx = (addr - base_q[v]) >> PAGE_SHIFT;
        if (idx >= PAGE_SLOTS)
            return ST_OUT;
        if (count_q[v] >= PAGE_SLOTS)
            return ST_FULL;
        if (count_q[v] != 0) begin
            link_tab[v][tail_q[v]] = idx[IDX_W-1:0];
        end else begin
            head_q[v] = idx[IDX_W-1:0];
        end
        link_tab[v][idx[IDX_W-1:0]] = '0;
        link_set[v][idx[IDX_W-1:0]] = 1'b1;
        tail_q[v]  = idx[IDX_W-1:0];
        count_q[v] = count_q[v] + 1'b1;
        return ST_OK;
    endfunction

    function automatic t_alloc_result free_list_step(input int v, input t_alloc_op op);
        t_alloc_result r;
        bit [63:0]     a;
        bit [63:0]     n;
        bit [63:0]     k;
        bit [63:0]     sum;
        r = '0;
        a = op.addr;
        case (op.func)
            FUNC_GET: begin
                if (count_q[v] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    sum = base_q[v] + (64'(head_q[v]) << PAGE_SHIFT);
                    r.addr = sum[ADDR_W-1:0];
                    head_q[v]  = link_tab[v][head_q[v]];
                    count_q[v] = count_q[v] - 1'b1;
                end
            end
            FUNC_PUT: r.status = link_page(v, a);
            FUNC_INIT: begin
                // the list is emptied even when the span is rejected
                head_q[v]  = '0;
                tail_q[v]  = '0;
                count_q[v] = '0;
                if ((a & PAGE_MASK64) != 0 || (op.bytes & PAGE_MASK64) != 0) begin
                    r.status = ST_MISALIGNED;
                end else begin
                    n = op.bytes >> PAGE_SHIFT;
                    // sweep stops at the first page that fails
                    for (k = 0; k < n && r.status == ST_OK; k++)
                        r.status = link_page(v, a + (k << PAGE_SHIFT));
                end
            end
            default: ;
        endcase
        r.free = count_q[v];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    function automatic bit [63:0] rand39();
        return {$urandom, $urandom} & ADDR_MASK64;
    endfunction

    // mostly short idles, a few long ones, none at all while calm
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic bit [63:0] pick_put_addr();
        int        r;
        int        slot;
        bit [63:0] b;
        bit [63:0] s;
        bit [63:0] a;
        b = base_q[VIEW_PLAN];
        s = size_q[VIEW_PLAN];
        r = $urandom_range(0, 99);
        if (r < 60 && recycled_pages.size() != 0) begin
            // hand back a page that a get took off the list
            slot = $urandom_range(0, recycled_pages.size() - 1);
            a = recycled_pages[slot];
            recycled_pages.delete(slot);
        end else if (r < 80 && s >= PAGE_BYTES) begin
            a = b + (64'($urandom_range(0, s / PAGE_BYTES - 1)) << PAGE_SHIFT);
        end else if (r < 88) begin
            a = (rand39() & ~PAGE_MASK64) | 64'($urandom_range(1, PAGE_BYTES - 1));
        end else if (r < 93) begin
            a = b - (64'($urandom_range(1, 4)) << PAGE_SHIFT);
        end else if (r < 97) begin
            a = b + s + (64'($urandom_range(0, 3)) << PAGE_SHIFT);
        end else begin
            a = rand39() & ~PAGE_MASK64;
        end
        return a & ADDR_MASK64;
    endfunction

    // ------------------------------------------------------------------------
    // planning: advance the planning view and queue the operation
    // ------------------------------------------------------------------------
    task automatic plan_op(input logic [FUNC_W-1:0] f, input bit [63:0] a, input bit [63:0] b);
        t_alloc_op     op;
        t_alloc_result r;
        op.func  = f;
        op.addr  = a[ADDR_W-1:0];
        op.bytes = b[SIZE_W-1:0];
        r = free_list_step(VIEW_PLAN, op);
        if (f == FUNC_GET && r.status == ST_OK)
            recycled_pages.push_back(64'(r.addr));
        if (f == FUNC_INIT)
            recycled_pages.delete();
        alloc_requests.push_back(op);
    endtask

    task automatic plan_init();
        int        r;
        bit [63:0] b;
        bit [63:0] npg;
        b   = base_q[VIEW_PLAN];
        npg = size_q[VIEW_PLAN] >> PAGE_SHIFT;
        r   = $urandom_range(0, 99);
        if (r < 8)
            plan_op(FUNC_INIT, rand39(), 64'($urandom_range(0, MAX_SPAN)));
        else if (r < 10)
            plan_op(FUNC_INIT, b, 64'($urandom_range(0, PAGE_SLOTS)) << PAGE_SHIFT);
        else if (r < 16)
            plan_op(FUNC_INIT, rand39() & ~PAGE_MASK64, 64'($urandom_range(0, 8)) << PAGE_SHIFT);
        else
            plan_op(FUNC_INIT, b + (64'($urandom_range(0, npg)) << PAGE_SHIFT),
                    64'($urandom_range(0, 24)) << PAGE_SHIFT);
    endtask

    task automatic plan_random(input int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // a head whose next pointer was never written must not be taken
                if (count_q[VIEW_PLAN] != 0 && !link_set[VIEW_PLAN][head_q[VIEW_PLAN]])
                    plan_init();
                else
                    plan_op(FUNC_GET, rand39(), 64'($urandom_range(0, MAX_SPAN)));
            end else if (pick < 85) begin
                plan_op(FUNC_PUT, pick_put_addr(), 64'($urandom_range(0, MAX_SPAN)));
            end else if (pick < 95) begin
                plan_init();
            end else begin
                plan_op(FUNC_SPARE, rand39(), 64'($urandom_range(0, MAX_SPAN)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // idle detection and register writes
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        // sampled on the falling edge, after all updates of the rising edge
        do @(negedge i_clk);
        while (alloc_requests.size() != 0 || i_in_valid || due_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_region(input bit [63:0] b, input bit [63:0] s);
        wait_idle();
        write_cfg(CFG_REGION_BASE, b[ADDR_W-1:0]);
        write_cfg(CFG_REGION_SIZE, {{(ADDR_W - SIZE_W){1'b0}}, s[SIZE_W-1:0]});
        for (int v = 0; v < 2; v++) begin
            base_q[v] = b & ADDR_MASK64;
            size_q[v] = s & SIZE_MASK64;
        end
        recycled_pages.delete();
        settings_done++;
    endtask

    // ------------------------------------------------------------------------
    // operation driver: one transfer at a time, random gaps between them
    // ------------------------------------------------------------------------
    int in_gap;
    bit in_calm;

    always @(posedge i_clk) begin : op_driver
        t_alloc_op op;
        // accepted operation: predict its result right away
        if (i_rst_n && i_in_valid && o_in_ready) begin
            op.func  = i_func;
            op.addr  = i_page_address;
            op.bytes = i_init_bytes;
            due_results.push_back(free_list_step(VIEW_CHECK, op));
        end
        // slot is free when nothing is offered or the offer just went through
        if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (i_rst_n && alloc_requests.size() != 0) begin
                op = alloc_requests.pop_front();
                i_in_valid     <= 1'b1;
                i_func         <= op.func;
                i_page_address <= op.addr;
                i_init_bytes   <= op.bytes;
                if ($urandom_range(0, 49) == 0)
                    in_calm = !in_calm;
                in_gap = idle_len(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and back-pressure
    // ------------------------------------------------------------------------
    int out_stall;
    bit out_calm;

    always @(posedge i_clk) begin : result_monitor
        t_alloc_result want;
        int            len;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result addr=%h free=%0d status=%0d",
                                          o_result_address, o_free_count, o_status));
            end else begin
                want = due_results.pop_front();
                if (o_result_address !== want.addr)
                    report_mismatch($sformatf("result address %h, want %h",
                                              o_result_address, want.addr));
                if (o_free_count !== want.free)
                    report_mismatch($sformatf("free count %0d, want %0d",
                                              o_free_count, want.free));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                results_seen++;
                status_hits[want.status]++;
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 49) == 0)
                out_calm = !out_calm;
            len = idle_len(out_calm);
            i_out_ready <= (len == 0);
            if (len > 0)
                out_stall = len - 1;
        end
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, due_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        bit [63:0] b;
        bit [63:0] s;

        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset region is empty: a get finds the list empty and a put is out of region
        plan_op(FUNC_GET, 0, 0);
        plan_op(FUNC_PUT, 0, 0);
        plan_op(FUNC_SPARE, ADDR_MASK64, MAX_SPAN);
        plan_op(FUNC_INIT, 0, 0);                        // empty span is fine

        // small eight-page region
        b = 64'h00_1234_5000;
        s = 8 * PAGE_BYTES;
        set_region(b, s);
        plan_op(FUNC_PUT, b + 64'h123, 0);               // misaligned page
        plan_op(FUNC_PUT, b - PAGE_BYTES, 0);            // just below the region
        plan_op(FUNC_PUT, b + s, 0);                     // first page past the end
        plan_op(FUNC_PUT, b + 7 * PAGE_BYTES, 0);
        plan_op(FUNC_PUT, b, 0);
        plan_op(FUNC_GET, 0, 0);                         // fifo order: last page first
        plan_op(FUNC_GET, 0, 0);
        plan_op(FUNC_INIT, b, s);
        plan_op(FUNC_INIT, b + 4 * PAGE_BYTES, s);       // runs off the end after four
        plan_op(FUNC_INIT, b, 64'h1001);                 // misaligned length
        plan_op(FUNC_INIT, b, 2 * PAGE_BYTES);
        plan_op(FUNC_PUT, b, 0);                         // same page linked twice
        plan_op(FUNC_GET, 0, 0);
        plan_op(FUNC_GET, 0, 0);
        plan_random(300);

        // region at the very top of the address space
        b = ADDR_MASK64 - 2 * PAGE_BYTES + 1;
        set_region(b, MAX_SPAN);
        plan_op(FUNC_INIT, b, 4 * PAGE_BYTES);           // third page wraps past 39 bits
        plan_op(FUNC_GET, 0, 0);
        plan_op(FUNC_PUT, ADDR_MASK64, 0);
        plan_random(200);

        // largest region from address zero: fill the list completely
        set_region(0, MAX_SPAN);
        plan_op(FUNC_INIT, 0, MAX_SPAN);
        plan_op(FUNC_PUT, 0, 0);                         // list is full
        plan_op(FUNC_GET, 0, 0);
        plan_random(750);

        // random small regions anywhere
        repeat (2) begin
            set_region(rand39() & ~PAGE_MASK64, 64'($urandom_range(1, 64)) << PAGE_SHIFT);
            plan_random(200);
        end

        // back to an empty region
        set_region(0, 0);
        plan_random(100);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("checked %0d results over %0d region settings, with stalls on both sides",
                 results_seen, settings_done);
        $display("status mix: ok %0d, empty %0d, misaligned %0d, out of region %0d, full %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_MISALIGNED],
                 status_hits[ST_OUT], status_hits[ST_FULL]);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
